// ===== hw/rtl/skl_pkg.sv =====
`timescale 1ns / 1ps

package skl_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int SCORE_W  = 7;
  localparam int MAX_SCORE = 100;

  typedef enum logic {
    OP_STORE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_STORED    = 2'd0,
    ST_FULL      = 2'd1,
    ST_FOUND     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_PLACE,
    S_PROBE,
    S_CMP
  } seq_state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
  } rec_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    rec_t              wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    status_t            status;
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
  } result_t;

  function automatic logic [SCORE_W-1:0] clamp_score(input logic signed [31:0] s);
    logic [SCORE_W-1:0] r;
    if (s < 0) begin
      r = '0;
    end else if (s > MAX_SCORE) begin
      r = SCORE_W'(MAX_SCORE);
    end else begin
      r = s[SCORE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/skl_mem.sv =====
`timescale 1ns / 1ps

module skl_mem (
  input  logic               clk,
  input  skl_pkg::mem_req_t  req,
  output skl_pkg::rec_t      rd_data
);

  skl_pkg::rec_t mem [skl_pkg::CAPACITY];
  skl_pkg::rec_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/skl_seq.sv =====
`timescale 1ns / 1ps

module skl_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  skl_pkg::op_t                  in_op,
  input  logic [skl_pkg::KEY_W-1:0]     in_key,
  input  logic [31:0]                   in_score_raw,
  input  logic                          out_free,
  output logic                          res_valid,
  output skl_pkg::result_t              res,
  output skl_pkg::mem_req_t             mem_req,
  input  skl_pkg::rec_t                 rd_data
);

  skl_pkg::seq_state_t                state_r, state_nxt;
  logic [skl_pkg::CNT_W-1:0]          count_r, count_nxt;
  logic [skl_pkg::ADDR_W-1:0]         idx_r, idx_nxt;
  logic [skl_pkg::CNT_W-1:0]          lo_r, lo_nxt;
  logic [skl_pkg::CNT_W-1:0]          hip1_r, hip1_nxt;
  logic [skl_pkg::ADDR_W-1:0]         mid_r, mid_nxt;
  logic [skl_pkg::KEY_W-1:0]          key_r, key_nxt;
  logic [skl_pkg::SCORE_W-1:0]        score_r, score_nxt;
  logic [skl_pkg::CNT_W-1:0]          span;
  logic [skl_pkg::CNT_W-1:0]          mid_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= skl_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    idx_r   <= idx_nxt;
    lo_r    <= lo_nxt;
    hip1_r  <= hip1_nxt;
    mid_r   <= mid_nxt;
    key_r   <= key_nxt;
    score_r <= score_nxt;
  end

  assign span     = hip1_r - lo_r - skl_pkg::CNT_W'(1);
  assign mid_full = lo_r + (span >> 1);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    lo_nxt        = lo_r;
    hip1_nxt      = hip1_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    score_nxt     = score_r;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    res.status    = skl_pkg::ST_STORED;
    res.key       = '0;
    res.score     = '0;
    mem_req.we    = 1'b0;
    mem_req.waddr = idx_r;
    mem_req.wdata = '{key: key_r, score: score_r};
    mem_req.raddr = idx_r - skl_pkg::ADDR_W'(2);

    case (state_r)
      skl_pkg::S_IDLE: begin
        in_ready = out_free;
        if (in_valid && out_free) begin
          key_nxt   = in_key;
          score_nxt = skl_pkg::clamp_score(in_score_raw);
          if (in_op == skl_pkg::OP_LOOKUP) begin
            lo_nxt    = '0;
            hip1_nxt  = count_r;
            state_nxt = skl_pkg::S_PROBE;
          end else if (count_r == skl_pkg::CNT_W'(skl_pkg::CAPACITY)) begin
            res_valid  = 1'b1;
            res.status = skl_pkg::ST_FULL;
          end else if (count_r == '0) begin
            idx_nxt   = '0;
            state_nxt = skl_pkg::S_PLACE;
          end else begin
            idx_nxt       = count_r[skl_pkg::ADDR_W-1:0];
            mem_req.raddr = count_r[skl_pkg::ADDR_W-1:0] - skl_pkg::ADDR_W'(1);
            state_nxt     = skl_pkg::S_SHIFT;
          end
        end
      end

      skl_pkg::S_SHIFT: begin
        mem_req.we = 1'b1;
        if ($signed(rd_data.key) > $signed(key_r)) begin
          mem_req.wdata = rd_data;
          idx_nxt       = idx_r - skl_pkg::ADDR_W'(1);
          if (idx_r == skl_pkg::ADDR_W'(1)) begin
            state_nxt = skl_pkg::S_PLACE;
          end
        end else begin
          count_nxt = count_r + skl_pkg::CNT_W'(1);
          res_valid = 1'b1;
          state_nxt = skl_pkg::S_IDLE;
        end
      end

      skl_pkg::S_PLACE: begin
        mem_req.we = 1'b1;
        count_nxt  = count_r + skl_pkg::CNT_W'(1);
        res_valid  = 1'b1;
        state_nxt  = skl_pkg::S_IDLE;
      end

      skl_pkg::S_PROBE: begin
        if (lo_r < hip1_r) begin
          mid_nxt       = mid_full[skl_pkg::ADDR_W-1:0];
          mem_req.raddr = mid_full[skl_pkg::ADDR_W-1:0];
          state_nxt     = skl_pkg::S_CMP;
        end else begin
          res_valid  = 1'b1;
          res.status = skl_pkg::ST_NOT_FOUND;
          state_nxt  = skl_pkg::S_IDLE;
        end
      end

      skl_pkg::S_CMP: begin
        if (rd_data.key == key_r) begin
          res_valid  = 1'b1;
          res.status = skl_pkg::ST_FOUND;
          res.key    = rd_data.key;
          res.score  = rd_data.score;
          state_nxt  = skl_pkg::S_IDLE;
        end else begin
          if ($signed(rd_data.key) < $signed(key_r)) begin
            lo_nxt = {1'b0, mid_r} + skl_pkg::CNT_W'(1);
          end else begin
            hip1_nxt = {1'b0, mid_r};
          end
          state_nxt = skl_pkg::S_PROBE;
        end
      end

      default: begin
        state_nxt = skl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/sorted_key_table_lookup.sv =====
`timescale 1ns / 1ps

// Keyed record table held in ascending key order, with a binary-search lookup.
// The input channel carries one beat per command: in_tuser selects a store or
// a lookup, in_tdata carries the key and the raw score. Every input beat gives
// exactly one result beat on the output channel, with a status in out_tuser.
// A store clamps the score to 0..100 and inserts the record after any records
// with an equal key. Starting from the top of the table, each stored record
// with a greater key moves up one place, and the result beat is given as the
// new record is written into the freed slot.
// The insertion pass reads and writes the single record memory once a cycle.
// A lookup alternates a probe state, which reads the middle record of the
// search range, and a compare state, which reports a hit or narrows the range;
// a miss is reported from the probe state once the range is empty. A store into
// a full table is answered with a table-full status at the edge that accepts the
// beat. The block works on one command at a time and takes a new beat only when
// idle and its output register is empty or being emptied; a stall on out_tready
// holds the result and keeps in_tready low. Reset clears the record count, the
// sequencer and the output register; the memory needs no clearing pass because
// entries above the count are never used.
module sorted_key_table_lookup (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // student_key [31:0], score_raw [63:32]
  input  logic        in_tuser,   // operation [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // found_key [31:0], found_score [38:32], zero [39]
  output logic [1:0]  out_tuser   // status [1:0]
);

  skl_pkg::mem_req_t mem_req;
  skl_pkg::rec_t     rd_data;
  skl_pkg::result_t  res;
  logic              res_valid;
  logic              out_free;
  logic              out_valid_r;
  skl_pkg::result_t  out_res_r;

  assign out_free = !out_valid_r || out_tready;

  skl_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  skl_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_op        (skl_pkg::op_t'(in_tuser)),
    .in_key       (in_tdata[31:0]),
    .in_score_raw (in_tdata[63:32]),
    .out_free     (out_free),
    .res_valid    (res_valid),
    .res          (res),
    .mem_req      (mem_req),
    .rd_data      (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {1'b0, out_res_r.score, out_res_r.key};

endmodule

// ===== bench/tb_sorted_key_table_lookup.sv =====
`timescale 1ns / 1ps

module tb_sorted_key_table_lookup;

  typedef struct {
    skl_pkg::op_t       op;
    logic signed [31:0] key;
    logic signed [31:0] score_raw;
  } table_cmd_t;

  typedef struct {
    skl_pkg::status_t            status;
    logic [skl_pkg::KEY_W-1:0]   key;
    logic [skl_pkg::SCORE_W-1:0] score;
  } table_reply_t;

  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam int RANDOM_CMDS = 1280;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;

  sorted_key_table_lookup DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted contents of the table.
  logic signed [31:0]          table_keys [skl_pkg::CAPACITY];
  logic [skl_pkg::SCORE_W-1:0] table_scores [skl_pkg::CAPACITY];
  int                          table_count = 0;

  table_cmd_t   cmd_queue[$];
  table_reply_t expected_replies[$];

  // Keys that the stimulus has placed in the table so far.
  logic signed [31:0] placed_keys[$];

  int total_cmds = 0;
  int accepted_cmds = 0;
  int error_count = 0;

  function automatic logic [skl_pkg::SCORE_W-1:0] limit_score(
    input logic signed [31:0] raw
  );
    logic [skl_pkg::SCORE_W-1:0] r;
    if (raw < 0) begin
      r = '0;
    end else if (raw > skl_pkg::MAX_SCORE) begin
      r = skl_pkg::SCORE_W'(skl_pkg::MAX_SCORE);
    end else begin
      r = raw[skl_pkg::SCORE_W-1:0];
    end
    return r;
  endfunction

  function automatic table_reply_t table_response(input table_cmd_t cmd);
    table_reply_t r;
    int pos;
    int lo;
    int hi;
    int mid;
    r.status = skl_pkg::ST_NOT_FOUND;
    r.key = '0;
    r.score = '0;
    if (cmd.op == skl_pkg::OP_STORE) begin
      if (table_count >= skl_pkg::CAPACITY) begin
        r.status = skl_pkg::ST_FULL;
      end else begin
        pos = table_count;
        while (pos > 0 && table_keys[pos-1] > cmd.key) pos--;
        for (int i = table_count; i > pos; i--) begin
          table_keys[i] = table_keys[i-1];
          table_scores[i] = table_scores[i-1];
        end
        table_keys[pos] = cmd.key;
        table_scores[pos] = limit_score(cmd.score_raw);
        table_count++;
        r.status = skl_pkg::ST_STORED;
      end
    end else begin
      lo = 0;
      hi = table_count - 1;
      while (lo <= hi && cmd.key >= table_keys[lo] && cmd.key <= table_keys[hi]) begin
        mid = lo + (hi - lo) / 2;
        if (table_keys[mid] == cmd.key) begin
          r.status = skl_pkg::ST_FOUND;
          r.key = table_keys[mid];
          r.score = table_scores[mid];
          break;
        end
        if (table_keys[mid] < cmd.key) begin
          lo = mid + 1;
        end else begin
          hi = mid - 1;
        end
      end
    end
    return r;
  endfunction

  task automatic push_cmd(input skl_pkg::op_t op, input logic signed [31:0] key,
                          input logic signed [31:0] score_raw);
    table_cmd_t c;
    c.op = op;
    c.key = key;
    c.score_raw = score_raw;
    cmd_queue.push_back(c);
    total_cmds++;
    if (op == skl_pkg::OP_STORE && placed_keys.size() < skl_pkg::CAPACITY) begin
      placed_keys.push_back(key);
    end
  endtask

  function automatic logic signed [31:0] edge_key();
    logic signed [31:0] k;
    case ($urandom_range(0, 4))
      0: k = KEY_MIN;
      1: k = KEY_MAX;
      2: k = 0;
      3: k = -1;
      default: k = 1;
    endcase
    return k;
  endfunction

  function automatic logic signed [31:0] random_score();
    logic signed [31:0] s;
    case ($urandom_range(0, 2))
      0: s = $signed($urandom_range(0, 110)) - 5;
      1: s = $urandom_range(0, skl_pkg::MAX_SCORE);
      default: s = $urandom;
    endcase
    return s;
  endfunction

  function automatic logic signed [31:0] store_key();
    logic signed [31:0] k;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      k = $urandom;
    end else if (pick < 70) begin
      k = $signed($urandom_range(0, 16)) - 8;
    end else if (pick < 85 && placed_keys.size() > 0) begin
      k = placed_keys[$urandom_range(0, placed_keys.size() - 1)];
    end else begin
      k = edge_key();
    end
    return k;
  endfunction

  function automatic logic signed [31:0] lookup_key();
    logic signed [31:0] k;
    int pick;
    pick = $urandom_range(0, 99);
    if (placed_keys.size() == 0 || pick >= 85) begin
      k = (pick[0]) ? $urandom : edge_key();
    end else begin
      k = placed_keys[$urandom_range(0, placed_keys.size() - 1)];
      if (pick >= 70) k = (pick[0]) ? k + 1 : k - 1;
    end
    return k;
  endfunction

  initial begin
    int store_pct;
    push_cmd(skl_pkg::OP_LOOKUP, 0, 0);
    push_cmd(skl_pkg::OP_LOOKUP, KEY_MAX, KEY_MIN);
    push_cmd(skl_pkg::OP_STORE, 0, KEY_MIN);
    push_cmd(skl_pkg::OP_LOOKUP, 0, KEY_MAX);
    push_cmd(skl_pkg::OP_STORE, KEY_MIN, KEY_MAX);
    push_cmd(skl_pkg::OP_STORE, KEY_MAX, 100);
    push_cmd(skl_pkg::OP_STORE, 0, 101);
    push_cmd(skl_pkg::OP_STORE, -1, -1);
    push_cmd(skl_pkg::OP_STORE, 1, 0);
    push_cmd(skl_pkg::OP_STORE, 0, 55);
    push_cmd(skl_pkg::OP_STORE, 5, 1);
    push_cmd(skl_pkg::OP_STORE, 32'sh5555_5555, 32'sh2AAA_AAAA);
    push_cmd(skl_pkg::OP_STORE, 32'shAAAA_AAAA, 32'sh5555_5555);
    push_cmd(skl_pkg::OP_LOOKUP, KEY_MIN, 0);
    push_cmd(skl_pkg::OP_LOOKUP, KEY_MAX, 0);
    push_cmd(skl_pkg::OP_LOOKUP, 0, 0);
    push_cmd(skl_pkg::OP_LOOKUP, -1, 0);
    push_cmd(skl_pkg::OP_LOOKUP, 1, 0);
    push_cmd(skl_pkg::OP_LOOKUP, 5, 0);
    push_cmd(skl_pkg::OP_LOOKUP, 3, 0);
    push_cmd(skl_pkg::OP_LOOKUP, KEY_MIN + 1, 0);
    push_cmd(skl_pkg::OP_LOOKUP, KEY_MAX - 1, 0);
    push_cmd(skl_pkg::OP_LOOKUP, 32'sh5555_5555, 0);
    push_cmd(skl_pkg::OP_LOOKUP, 32'shAAAA_AAAA, 0);

    // Fill the table at a moderate pace, then keep looking up once it is full
    // while stores into it are turned away.
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      store_pct = (placed_keys.size() < skl_pkg::CAPACITY) ? 45 : 25;
      if ($urandom_range(0, 99) < store_pct) begin
        push_cmd(skl_pkg::OP_STORE, store_key(), random_score());
      end else begin
        push_cmd(skl_pkg::OP_LOOKUP, lookup_key(), $urandom);
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_cmds < total_cmds || expected_replies.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  table_cmd_t held_cmd;
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        expected_replies.push_back(table_response(held_cmd));
        accepted_cmds++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        held_cmd = cmd_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {held_cmd.score_raw, held_cmd.key};
        in_tuser <= held_cmd.op;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 15);
        end else begin
          burst_left--;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  int stall_left = 0;
  int steady_left = 0;

  always @(posedge clk) begin
    table_reply_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_replies.size() == 0) begin
          $error("result beat with no command outstanding: status %0d key %0d score %0d",
                 out_tuser, $signed(out_tdata[31:0]), out_tdata[38:32]);
          error_count++;
        end else begin
          want = expected_replies.pop_front();
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_tuser);
            error_count++;
          end
          if (out_tdata[31:0] !== want.key) begin
            $error("found_key: expected %0d, actual %0d", $signed(want.key),
                   $signed(out_tdata[31:0]));
            error_count++;
          end
          if (out_tdata[38:32] !== want.score) begin
            $error("found_score: expected %0d, actual %0d", want.score, out_tdata[38:32]);
            error_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (steady_left > 0) begin
          steady_left--;
        end else if ($urandom_range(0, 99) == 0) begin
          steady_left = $urandom_range(200, 600);
        end else if ($urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 12);
        end
      end
    end
  end

endmodule
